>>> rtl/integer_stack_machine_execute_top_assert.svh
// assertion macros for the integer stack machine execute block
`ifndef INTEGER_STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define INTEGER_STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ISM_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled during reset
`define ISM_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/ism_pkg.sv
// shared types, opcodes and constants for the integer stack machine
package ism_pkg;

  localparam int DATA_W            = 64;
  localparam int PC_W              = 32;
  localparam int STACK_DEPTH_DEF   = 64;
  localparam int VAR_COUNT_DEF     = 256;
  localparam int FIXED_VARS        = 4;

  localparam logic [5:0] OP_INVALID = 6'd0;
  localparam logic [5:0] OP_LDI     = 6'd1;
  localparam logic [5:0] OP_LD0     = 6'd2;
  localparam logic [5:0] OP_LD1     = 6'd3;
  localparam logic [5:0] OP_LDM1    = 6'd4;
  localparam logic [5:0] OP_ADD     = 6'd5;
  localparam logic [5:0] OP_SUB     = 6'd6;
  localparam logic [5:0] OP_MUL     = 6'd7;
  localparam logic [5:0] OP_DIV     = 6'd8;
  localparam logic [5:0] OP_MOD     = 6'd9;
  localparam logic [5:0] OP_NEG     = 6'd10;
  localparam logic [5:0] OP_PRINT   = 6'd11;
  localparam logic [5:0] OP_SWAP    = 6'd12;
  localparam logic [5:0] OP_POP     = 6'd13;
  localparam logic [5:0] OP_LDF0    = 6'd14;
  localparam logic [5:0] OP_LDF1    = 6'd15;
  localparam logic [5:0] OP_LDF2    = 6'd16;
  localparam logic [5:0] OP_LDF3    = 6'd17;
  localparam logic [5:0] OP_STF0    = 6'd18;
  localparam logic [5:0] OP_STF1    = 6'd19;
  localparam logic [5:0] OP_STF2    = 6'd20;
  localparam logic [5:0] OP_STF3    = 6'd21;
  localparam logic [5:0] OP_LDV     = 6'd22;
  localparam logic [5:0] OP_STV     = 6'd23;
  localparam logic [5:0] OP_CMP     = 6'd24;
  localparam logic [5:0] OP_DUMP    = 6'd25;
  localparam logic [5:0] OP_STOP    = 6'd26;
  localparam logic [5:0] OP_JMP     = 6'd27;
  localparam logic [5:0] OP_BNE     = 6'd28;
  localparam logic [5:0] OP_BEQ     = 6'd29;
  localparam logic [5:0] OP_BGT     = 6'd30;
  localparam logic [5:0] OP_BGE     = 6'd31;
  localparam logic [5:0] OP_BLT     = 6'd32;
  localparam logic [5:0] OP_BLE     = 6'd33;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_STOP  = 3'd1;
  localparam logic [2:0] ST_HALT  = 3'd2;
  localparam logic [2:0] ST_UNDER = 3'd3;
  localparam logic [2:0] ST_OVER  = 3'd4;
  localparam logic [2:0] ST_DIV0  = 3'd5;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_SHIFT_IN,
    CELL_SHIFT_OUT,
    CELL_WRITE
  } ism_cell_cmd_t;

  typedef struct packed {
    ism_cell_cmd_t       cmd;
    logic [DATA_W-1:0]   wr_data;
  } ism_cell_ctl_t;

  typedef enum logic [1:0] {
    MU_MUL,
    MU_DIV,
    MU_MOD
  } ism_mu_op_t;

  typedef struct packed {
    logic                start;
    ism_mu_op_t          op;
    logic [DATA_W-1:0]   a;
    logic [DATA_W-1:0]   b;
  } ism_mu_req_t;

  typedef struct packed {
    logic                busy;
    logic                done;
    logic [DATA_W-1:0]   result;
  } ism_mu_resp_t;

  typedef enum logic [1:0] {
    M_IDLE,
    M_MUL,
    M_DIV,
    M_FIX
  } ism_mu_state_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC,
    S_ARITH,
    S_OUT
  } ism_state_t;

endpackage

>>> rtl/ism_if.sv
// valid/ready channels for instruction beats and result beats
interface ism_in_if;
  import ism_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [5:0]                mode;
  logic signed [DATA_W-1:0]  immediate;
  logic [7:0]                var_slot;
  logic signed [15:0]        jump_offset;
  logic [3:0]                insn_length;

  modport source (output valid, mode, immediate, var_slot, jump_offset, insn_length,
                  input ready);
  modport sink   (input valid, mode, immediate, var_slot, jump_offset, insn_length,
                  output ready);
endinterface

interface ism_out_if;
  import ism_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [PC_W-1:0]           next_pc;
  logic                      print_valid;
  logic signed [DATA_W-1:0]  print_value;
  logic [2:0]                status;

  modport source (output valid, next_pc, print_valid, print_value, status, input ready);
  modport sink   (input valid, next_pc, print_valid, print_value, status, output ready);
endinterface

>>> rtl/ism_cell.sv
// one operand stack cell: holds an entry and trades it with its neighbors
module ism_cell (
  input  logic                          clk,
  input  ism_pkg::ism_cell_ctl_t        ctl,
  input  logic [ism_pkg::DATA_W-1:0]    shallow_data,
  input  logic [ism_pkg::DATA_W-1:0]    deep_data,
  output logic [ism_pkg::DATA_W-1:0]    data
);
  import ism_pkg::*;

  always_ff @(posedge clk) begin
    case (ctl.cmd)
      CELL_SHIFT_IN:  data <= shallow_data;
      CELL_SHIFT_OUT: data <= deep_data;
      CELL_WRITE:     data <= ctl.wr_data;
      default:        data <= data;
    endcase
  end

endmodule

>>> rtl/ism_mulu.sv
// multi-cycle multiply and signed divide/modulo unit
module ism_mulu (
  input  logic                   clk,
  input  logic                   rst,
  input  ism_pkg::ism_mu_req_t   req,
  output ism_pkg::ism_mu_resp_t  resp
);
  import ism_pkg::*;

  localparam int HALF_W = DATA_W / 2;
  localparam int CNT_W  = $clog2(DATA_W);

  ism_mu_state_t        mstate;
  ism_mu_state_t        mstate_next;
  logic [CNT_W-1:0]     cnt;
  ism_mu_op_t           op_reg;
  logic [DATA_W-1:0]    a_reg;
  logic [DATA_W-1:0]    b_reg;
  logic [DATA_W-1:0]    acc;
  logic [DATA_W-1:0]    prod;
  logic [DATA_W-1:0]    quo;
  logic [DATA_W-1:0]    rem;
  logic                 neg_q;
  logic                 neg_r;
  logic [DATA_W-1:0]    rem_sh;
  logic [DATA_W:0]      trial;
  logic [DATA_W-1:0]    mag_a;
  logic [DATA_W-1:0]    mag_b;

  assign mag_a  = req.a[DATA_W-1] ? (~req.a + 1'b1) : req.a;
  assign mag_b  = req.b[DATA_W-1] ? (~req.b + 1'b1) : req.b;
  assign rem_sh = {rem[DATA_W-2:0], quo[DATA_W-1]};
  assign trial  = {1'b0, rem_sh} - {1'b0, b_reg};

  always_ff @(posedge clk) begin
    if (rst) begin
      mstate <= M_IDLE;
    end else begin
      mstate <= mstate_next;
    end
  end

  always_comb begin
    mstate_next = mstate;
    case (mstate)
      M_IDLE: begin
        if (req.start) begin
          mstate_next = (req.op == MU_MUL) ? M_MUL : M_DIV;
        end
      end
      M_MUL: begin
        if (cnt == CNT_W'(3)) begin
          mstate_next = M_FIX;
        end
      end
      M_DIV: begin
        if (cnt == CNT_W'(DATA_W - 1)) begin
          mstate_next = M_FIX;
        end
      end
      M_FIX:   mstate_next = M_IDLE;
      default: mstate_next = M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    case (mstate)
      M_IDLE: begin
        cnt    <= '0;
        op_reg <= req.op;
        a_reg  <= req.a;
        rem    <= '0;
        acc    <= '0;
        neg_q  <= req.a[DATA_W-1] ^ req.b[DATA_W-1];
        neg_r  <= req.a[DATA_W-1];
        if (req.op == MU_MUL) begin
          b_reg <= req.b;
        end else begin
          b_reg <= mag_b;
          quo   <= mag_a;
        end
      end
      M_MUL: begin
        cnt <= cnt + 1'b1;
        // low 64 bits from three 32x32 partial products
        case (cnt[1:0])
          2'd0: prod <= a_reg[HALF_W-1:0] * b_reg[HALF_W-1:0];
          2'd1: begin
            acc  <= prod;
            prod <= a_reg[HALF_W-1:0] * b_reg[DATA_W-1:HALF_W];
          end
          2'd2: begin
            acc  <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
            prod <= a_reg[DATA_W-1:HALF_W] * b_reg[HALF_W-1:0];
          end
          default: acc <= acc + {prod[HALF_W-1:0], {HALF_W{1'b0}}};
        endcase
      end
      M_DIV: begin
        cnt <= cnt + 1'b1;
        if (!trial[DATA_W]) begin
          rem <= trial[DATA_W-1:0];
          quo <= {quo[DATA_W-2:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[DATA_W-2:0], 1'b0};
        end
      end
      default: cnt <= '0;
    endcase
  end

  always_comb begin
    resp.busy = (mstate != M_IDLE);
    resp.done = (mstate == M_FIX);
    case (op_reg)
      MU_MUL:  resp.result = acc;
      MU_DIV:  resp.result = neg_q ? (~quo + 1'b1) : quo;
      MU_MOD:  resp.result = neg_r ? (~rem + 1'b1) : rem;
      default: resp.result = acc;
    endcase
  end

endmodule

>>> rtl/integer_stack_machine_execute_top.sv
// Integer stack machine execute stage. Each instruction beat on insn runs one
// decoded opcode against a 64-bit operand stack and gives exactly one beat on
// result with the new program counter, a printed value and a status code.
// The operand stack is a row of STACK_DEPTH cells with the top in cell 0:
// a push shifts every cell one place deeper, a pop shifts every cell one place
// up, and binary ops rewrite cell 0 while the rest moves up. Fixed variables
// are four registers; indexed variables live in a VAR_COUNT-entry memory
// whose registered read is started when the instruction is accepted.
// Most instructions pass through accept, then execute and load the output
// register. Multiply waits on three 32x32 partial products in the shared
// multiply/divide unit; divide and modulo wait on its one-bit-per-cycle
// restoring divider. A zero divisor finishes without the unit. After reset
// the block clears the indexed variable memory before it accepts its first
// beat. A result beat that is not yet taken does not block the next
// instruction from being accepted. An invalid opcode halts the block until
// reset; every later beat returns the unchanged counter with the halted
// status.
module integer_stack_machine_execute_top #(
  parameter int STACK_DEPTH = ism_pkg::STACK_DEPTH_DEF,
  parameter int VAR_COUNT   = ism_pkg::VAR_COUNT_DEF
) (
  input  logic          clk,
  input  logic          rst,
  ism_in_if.sink        insn,
  ism_out_if.source     result
);
  import ism_pkg::*;

  `include "integer_stack_machine_execute_top_assert.svh"

  localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);
  localparam int VAR_W   = $clog2(VAR_COUNT);
  localparam logic [16:0] VAR_LIMIT = 17'(VAR_COUNT);

  // slot modulo VAR_COUNT, one bit a step
  function automatic logic [VAR_W-1:0] slot_reduce(input logic [7:0] v);
    logic [16:0] r;
    r = '0;
    for (int i = 7; i >= 0; i--) begin
      r = {r[15:0], v[i]};
      if (r >= VAR_LIMIT) begin
        r = r - VAR_LIMIT;
      end
    end
    return r[VAR_W-1:0];
  endfunction

  // control state
  ism_state_t               state;
  ism_state_t               state_next;
  logic [VAR_W-1:0]         clr_cnt;
  logic [PC_W-1:0]          pc;
  logic [DEPTH_W-1:0]       depth;
  logic                     halted;

  // latched instruction
  logic [5:0]               in_op;
  logic [DATA_W-1:0]        in_imm;
  logic [VAR_W-1:0]         in_slot;
  logic signed [15:0]       in_off;
  logic [3:0]               in_len;

  // stack cells
  logic [DATA_W-1:0]        cell_data [STACK_DEPTH];
  ism_cell_ctl_t            cell_ctl  [STACK_DEPTH];

  // variable storage
  logic [DATA_W-1:0]        fixed_vars [FIXED_VARS];
  logic [DATA_W-1:0]        var_mem    [VAR_COUNT];
  logic [DATA_W-1:0]        mem_rdata;

  // pending result
  logic [PC_W-1:0]          res_pc;
  logic                     res_pv;
  logic [DATA_W-1:0]        res_pval;
  logic [2:0]               res_st;

  // output register
  logic                     out_vld;
  logic [PC_W-1:0]          out_pc;
  logic                     out_pv;
  logic [DATA_W-1:0]        out_pval;
  logic [2:0]               out_st;

  // datapath decisions
  ism_cell_cmd_t            cmd0;
  ism_cell_cmd_t            cmd1;
  ism_cell_cmd_t            cmdn;
  logic [DATA_W-1:0]        wr0;
  logic [DATA_W-1:0]        wr1;
  logic [DATA_W-1:0]        push_val;
  logic [DEPTH_W-1:0]       depth_next;
  logic                     halted_next;
  logic [2:0]               st_c;
  logic                     pv_c;
  logic [DATA_W-1:0]        pval_c;
  logic                     jump;
  logic [PC_W-1:0]          npc_c;
  logic                     fx_we;
  logic [1:0]               fx_idx;
  logic                     mem_we;
  logic [VAR_W-1:0]         mem_waddr;
  logic [DATA_W-1:0]        mem_wdata;
  logic                     go_arith;
  logic                     halt_now;
  logic [DATA_W-1:0]        top_a;
  logic [DATA_W-1:0]        top_b;
  logic [5:0]               ld_rel;
  logic [5:0]               st_rel;
  logic                     stack_full;
  logic                     has1;
  logic                     has2;
  logic                     a_lt_b;
  logic                     b_lt_a;
  ism_mu_req_t              mu_req;
  ism_mu_resp_t             mu_resp;

  // output path
  logic                     in_acc;
  logic                     out_free;
  logic                     fin;
  logic                     out_load;
  logic [PC_W-1:0]          o_pc;
  logic                     o_pv;
  logic [DATA_W-1:0]        o_pval;
  logic [2:0]               o_st;

  assign top_a      = cell_data[0];
  assign top_b      = cell_data[1];
  assign stack_full = (depth == DEPTH_W'(STACK_DEPTH));
  assign has1       = (depth != '0);
  assign has2       = (depth >= DEPTH_W'(2));
  assign a_lt_b     = $signed(top_a) < $signed(top_b);
  assign b_lt_a     = $signed(top_b) < $signed(top_a);
  assign ld_rel     = in_op - OP_LDF0;
  assign st_rel     = in_op - OP_STF0;
  assign halt_now   = halted || (in_op == OP_INVALID);

  assign insn.ready = (state == S_IDLE);
  assign in_acc     = insn.valid && insn.ready;
  assign out_free   = !out_vld || result.ready;

  // the stack row
  for (genvar i = 0; i < STACK_DEPTH; i++) begin : g_cell
    logic [DATA_W-1:0] shallow;
    logic [DATA_W-1:0] deep;
    if (i == 0) begin : g_top
      assign shallow     = push_val;
      assign cell_ctl[i] = '{cmd: cmd0, wr_data: wr0};
    end else if (i == 1) begin : g_second
      assign shallow     = cell_data[i-1];
      assign cell_ctl[i] = '{cmd: cmd1, wr_data: wr1};
    end else begin : g_rest
      assign shallow     = cell_data[i-1];
      assign cell_ctl[i] = '{cmd: cmdn, wr_data: '0};
    end
    if (i == STACK_DEPTH - 1) begin : g_bottom
      assign deep = '0;
    end else begin : g_inner
      assign deep = cell_data[i+1];
    end
    ism_cell u_cell (
      .clk          (clk),
      .ctl          (cell_ctl[i]),
      .shallow_data (shallow),
      .deep_data    (deep),
      .data         (cell_data[i])
    );
  end

  ism_mulu u_mulu (
    .clk  (clk),
    .rst  (rst),
    .req  (mu_req),
    .resp (mu_resp)
  );

  // instruction execution
  always_comb begin
    cmd0        = CELL_HOLD;
    cmd1        = CELL_HOLD;
    cmdn        = CELL_HOLD;
    wr0         = '0;
    wr1         = '0;
    push_val    = '0;
    depth_next  = depth;
    halted_next = halted;
    st_c        = ST_OK;
    pv_c        = 1'b0;
    pval_c      = '0;
    jump        = 1'b0;
    fx_we       = 1'b0;
    fx_idx      = st_rel[1:0];
    mem_we      = 1'b0;
    mem_waddr   = in_slot;
    mem_wdata   = top_a;
    go_arith    = 1'b0;
    mu_req      = '{start: 1'b0, op: MU_MUL, a: top_a, b: top_b};

    if (state == S_CLEAR) begin
      mem_we    = 1'b1;
      mem_waddr = clr_cnt;
      mem_wdata = '0;
    end else if (state == S_ARITH) begin
      if (mu_resp.done) begin
        cmd0       = CELL_WRITE;
        wr0        = mu_resp.result;
        cmd1       = CELL_SHIFT_OUT;
        cmdn       = CELL_SHIFT_OUT;
        depth_next = depth - 1'b1;
      end
    end else if (state == S_EXEC) begin
      if (halt_now) begin
        halted_next = 1'b1;
        st_c        = ST_HALT;
      end else begin
        case (in_op)
          OP_LDI, OP_LD0, OP_LD1, OP_LDM1, OP_LDF0, OP_LDF1, OP_LDF2, OP_LDF3,
          OP_LDV: begin
            if (stack_full) begin
              st_c = ST_OVER;
            end else begin
              cmd0       = CELL_SHIFT_IN;
              cmd1       = CELL_SHIFT_IN;
              cmdn       = CELL_SHIFT_IN;
              depth_next = depth + 1'b1;
              case (in_op)
                OP_LDI:  push_val = in_imm;
                OP_LD0:  push_val = '0;
                OP_LD1:  push_val = DATA_W'(1);
                OP_LDM1: push_val = '1;
                OP_LDV:  push_val = mem_rdata;
                default: push_val = fixed_vars[ld_rel[1:0]];
              endcase
            end
          end
          OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD: begin
            if (!has2) begin
              // too few operands: a zero goes on the stack
              st_c       = ST_UNDER;
              cmd0       = CELL_SHIFT_IN;
              cmd1       = CELL_SHIFT_IN;
              cmdn       = CELL_SHIFT_IN;
              depth_next = depth + 1'b1;
            end else if (in_op == OP_ADD || in_op == OP_SUB ||
                         top_b == '0) begin
              cmd0       = CELL_WRITE;
              cmd1       = CELL_SHIFT_OUT;
              cmdn       = CELL_SHIFT_OUT;
              depth_next = depth - 1'b1;
              if (in_op == OP_ADD) begin
                wr0 = top_a + top_b;
              end else if (in_op == OP_SUB) begin
                wr0 = top_a - top_b;
              end else if (in_op == OP_MUL) begin
                // zero multiplier needs no unit
                wr0 = '0;
              end else begin
                wr0  = '0;
                st_c = ST_DIV0;
              end
            end else begin
              go_arith     = 1'b1;
              mu_req.start = 1'b1;
              if (in_op == OP_MUL) begin
                mu_req.op = MU_MUL;
              end else if (in_op == OP_DIV) begin
                mu_req.op = MU_DIV;
              end else begin
                mu_req.op = MU_MOD;
              end
            end
          end
          OP_NEG: begin
            if (!has1) begin
              st_c       = ST_UNDER;
              cmd0       = CELL_SHIFT_IN;
              cmd1       = CELL_SHIFT_IN;
              cmdn       = CELL_SHIFT_IN;
              depth_next = depth + 1'b1;
            end else begin
              cmd0 = CELL_WRITE;
              wr0  = '0 - top_a;
            end
          end
          OP_PRINT, OP_POP, OP_STF0, OP_STF1, OP_STF2, OP_STF3, OP_STV: begin
            if (!has1) begin
              st_c = ST_UNDER;
            end else begin
              cmd0       = CELL_SHIFT_OUT;
              cmd1       = CELL_SHIFT_OUT;
              cmdn       = CELL_SHIFT_OUT;
              depth_next = depth - 1'b1;
              if (in_op == OP_PRINT) begin
                pv_c   = 1'b1;
                pval_c = top_a;
              end else if (in_op == OP_STV) begin
                mem_we = 1'b1;
              end else if (in_op != OP_POP) begin
                fx_we = 1'b1;
              end
            end
          end
          OP_SWAP: begin
            if (!has2) begin
              st_c = ST_UNDER;
            end else begin
              cmd0 = CELL_WRITE;
              wr0  = top_b;
              cmd1 = CELL_WRITE;
              wr1  = top_a;
            end
          end
          OP_CMP: begin
            if (!has2) begin
              st_c       = ST_UNDER;
              cmd0       = CELL_SHIFT_IN;
              cmd1       = CELL_SHIFT_IN;
              cmdn       = CELL_SHIFT_IN;
              depth_next = depth + 1'b1;
            end else if (stack_full) begin
              st_c = ST_OVER;
            end else begin
              cmd0       = CELL_SHIFT_IN;
              cmd1       = CELL_SHIFT_IN;
              cmdn       = CELL_SHIFT_IN;
              depth_next = depth + 1'b1;
              if (a_lt_b) begin
                push_val = '1;
              end else if (top_a == top_b) begin
                push_val = '0;
              end else begin
                push_val = DATA_W'(1);
              end
            end
          end
          OP_DUMP: begin
            if (!has1) begin
              st_c = ST_UNDER;
            end else begin
              pv_c   = 1'b1;
              pval_c = top_a;
            end
          end
          OP_STOP: st_c = ST_STOP;
          OP_JMP:  jump = 1'b1;
          OP_BNE, OP_BEQ, OP_BGT, OP_BGE, OP_BLT, OP_BLE: begin
            if (!has2) begin
              st_c = ST_UNDER;
            end else begin
              case (in_op)
                OP_BNE:  jump = (top_a != top_b);
                OP_BEQ:  jump = (top_a == top_b);
                OP_BGT:  jump = b_lt_a;
                OP_BGE:  jump = !a_lt_b;
                OP_BLT:  jump = a_lt_b;
                default: jump = !b_lt_a;
              endcase
            end
          end
          default: begin
            // unknown opcode: only the counter moves
            st_c = ST_OK;
          end
        endcase
      end
    end

    if (halt_now) begin
      npc_c = pc;
    end else if (jump) begin
      npc_c = pc + PC_W'(in_off) + PC_W'(1);
    end else begin
      npc_c = pc + PC_W'(in_len);
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_CLEAR: begin
        if (clr_cnt == VAR_W'(VAR_COUNT - 1)) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_acc) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (go_arith) begin
          state_next = S_ARITH;
        end else begin
          state_next = out_free ? S_IDLE : S_OUT;
        end
      end
      S_ARITH: begin
        if (mu_resp.done) begin
          state_next = out_free ? S_IDLE : S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    fin    = 1'b0;
    o_pc   = res_pc;
    o_pv   = res_pv;
    o_pval = res_pval;
    o_st   = res_st;
    case (state)
      S_EXEC: begin
        fin    = !go_arith;
        o_pc   = npc_c;
        o_pv   = pv_c;
        o_pval = pval_c;
        o_st   = st_c;
      end
      S_ARITH: fin = mu_resp.done;
      S_OUT:   fin = 1'b1;
      default: fin = 1'b0;
    endcase
    out_load = fin && out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_cnt <= '0;
      pc      <= '0;
      depth   <= '0;
      halted  <= 1'b0;
      out_vld <= 1'b0;
      for (int i = 0; i < FIXED_VARS; i++) begin
        fixed_vars[i] <= '0;
      end
    end else begin
      state   <= state_next;
      depth   <= depth_next;
      halted  <= halted_next;
      if (state == S_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (state == S_EXEC) begin
        pc <= npc_c;
      end
      if (fx_we) begin
        fixed_vars[fx_idx] <= top_a;
      end
      if (out_load) begin
        out_vld <= 1'b1;
      end else if (result.ready) begin
        out_vld <= 1'b0;
      end
    end
  end

  // instruction latch, pending result and output payload
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_op   <= insn.mode;
      in_imm  <= insn.immediate;
      in_slot <= slot_reduce(insn.var_slot);
      in_off  <= insn.jump_offset;
      in_len  <= insn.insn_length;
    end
    if (state == S_EXEC) begin
      res_pc   <= npc_c;
      res_pv   <= pv_c;
      res_pval <= pval_c;
      res_st   <= st_c;
    end
    if (out_load) begin
      out_pc   <= o_pc;
      out_pv   <= o_pv;
      out_pval <= o_pval;
      out_st   <= o_st;
    end
  end

  // indexed variable memory, read started at accept
  always_ff @(posedge clk) begin
    if (mem_we) begin
      var_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata <= var_mem[slot_reduce(insn.var_slot)];
  end

  assign result.valid       = out_vld;
  assign result.next_pc     = out_pc;
  assign result.print_valid = out_pv;
  assign result.print_value = out_pval;
  assign result.status      = out_st;

  `ISM_ASSERT_IMP(a_depth_bound, clk, rst, 1'b1, depth <= DEPTH_W'(STACK_DEPTH), "stack depth beyond row length")
  `ISM_ASSERT_NXT(a_halt_sticky, clk, rst, halted, halted, "halt cleared without reset")
  `ISM_ASSERT_IMP(a_mu_owned, clk, rst, state != S_ARITH, !mu_resp.busy, "multiply/divide unit busy outside arith wait")
  `ISM_ASSERT_NXT(a_halt_status, clk, rst, halted && out_load, result.status == ST_HALT, "halted block gave a non-halt status")

endmodule
